// ===== sv/ptts_pkg.sv =====
package ptts_pkg;

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 16;
    localparam int SUS_W   = 8;
    localparam int MASK_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_SUSPEND = 3'd3,
        OP_RESUME  = 3'd4,
        OP_QUERY   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_EMPTY     = 2'd0,
        MODE_READY     = 2'd1,
        MODE_RUNNING   = 2'd2,
        MODE_SUSPENDED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TAKEN = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Request travelling down the slot chain, gathering its result on the way
    typedef struct packed {
        logic              valid;
        opcode_t           op;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  first_delay;
        logic [SUS_W-1:0]  suspend_time;
        status_t           status;
        mode_t             task_state;
        logic [MASK_W-1:0] fire_mask;
    } pkt_t;

endpackage

// ===== sv/ptts_cell.sv =====
module ptts_cell #(
    parameter int INDEX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  ptts_pkg::pkt_t pkt_in,
    output ptts_pkg::pkt_t pkt_out
);
    import ptts_pkg::*;

    // Fire bit of this slot; slots from eight upward have none
    localparam logic [MASK_W-1:0] FIRE_BIT = MASK_W'(1 << INDEX);

    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  per_reg, per_next;
    logic [SUS_W-1:0]  sus_reg, sus_next;
    pkt_t              pkt_reg, pkt_next;
    logic              hit;

    // Act on the request passing this slot
    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        per_next  = per_reg;
        sus_next  = sus_reg;
        pkt_next  = pkt_in;
        hit       = (pkt_in.slot == SLOT_W'(INDEX));
        if (pkt_in.valid)
        begin
            case (pkt_in.op)
                OP_TICK:
                begin
                    case (mode_reg)
                        MODE_READY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                pkt_next.fire_mask = pkt_in.fire_mask | FIRE_BIT;
                                mode_next = MODE_RUNNING;
                                cnt_next  = per_reg;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        MODE_RUNNING:
                        begin
                            if (cnt_reg == '0)
                                mode_next = MODE_READY;
                            else
                                cnt_next = cnt_reg - 1'b1;
                        end
                        MODE_SUSPENDED:
                        begin
                            if (sus_reg == '0)
                                mode_next = MODE_READY;
                            else
                                sus_next = sus_reg - 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_CREATE:
                begin
                    if (hit)
                    begin
                        if (mode_reg != MODE_EMPTY)
                        begin
                            pkt_next.status = ST_TAKEN;
                        end
                        else
                        begin
                            per_next  = pkt_in.period;
                            cnt_next  = pkt_in.first_delay;
                            sus_next  = '0;
                            mode_next = MODE_READY;
                        end
                    end
                end
                OP_DELETE:
                begin
                    if (hit)
                    begin
                        mode_next = MODE_EMPTY;
                        cnt_next  = '0;
                        per_next  = '0;
                        sus_next  = '0;
                    end
                end
                OP_SUSPEND:
                begin
                    if (hit)
                    begin
                        if (mode_reg == MODE_EMPTY)
                        begin
                            pkt_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            mode_next = MODE_SUSPENDED;
                            sus_next  = pkt_in.suspend_time;
                        end
                    end
                end
                OP_RESUME:
                begin
                    if (hit)
                    begin
                        if (mode_reg == MODE_EMPTY)
                            pkt_next.status = ST_EMPTY;
                        else
                            mode_next = MODE_READY;
                    end
                end
                OP_QUERY:
                begin
                    if (hit)
                    begin
                        if (mode_reg == MODE_EMPTY)
                            pkt_next.status = ST_EMPTY;
                        else
                            pkt_next.task_state = mode_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold everything while the chain is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EMPTY;
            cnt_reg  <= '0;
            per_reg  <= '0;
            sus_reg  <= '0;
            pkt_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            per_reg  <= per_next;
            sus_reg  <= sus_next;
            pkt_reg  <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

// ===== sv/periodic_task_tick_scheduler.sv =====
// Periodic task tick scheduler.
// Input channel (in_valid/in_ready) takes one request: opcode, slot, period,
// first_delay, suspend_time. Output channel (out_valid/out_ready) returns one
// result per request: status, task_state, fire_mask.
// Each task slot lives in its own cell; the cells form a chain and a request
// walks down it one cell per cycle unless the chain is frozen (see below), so
// every slot sees every request. A tick updates all slots as it passes; other
// opcodes act only in the addressed cell. The result passes through the entry
// register, each cell's register and the output register before it is valid.
// Only one request is in flight at a time; in_ready rises again once the
// result sits in the output register, so a new request is taken while that
// result still waits.
// If the receiver stalls with a result still held, a finished request at the
// chain's end freezes the whole chain until the output register frees up.
// Reset clears every slot to empty and drops any request in flight.
module periodic_task_tick_scheduler #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptts_pkg::OP_W-1:0]     opcode,
    input  logic [ptts_pkg::SLOT_W-1:0]   slot,
    input  logic [ptts_pkg::CNT_W-1:0]    period,
    input  logic [ptts_pkg::CNT_W-1:0]    first_delay,
    input  logic [ptts_pkg::SUS_W-1:0]    suspend_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [1:0]                    task_state,
    output logic [ptts_pkg::MASK_W-1:0]   fire_mask
);
    import ptts_pkg::*;

    pkt_t    chain [TASK_SLOTS+1];
    pkt_t    entry_reg, entry_next;
    pkt_t    exit_pkt;
    logic    busy_reg, busy_next;
    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    mode_t   state_reg, state_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic    accept;
    logic    advance;
    opcode_t op_in;
    logic    slot_range;

    assign exit_pkt = chain[TASK_SLOTS];
    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    // Freeze the chain while a finished request cannot leave
    assign advance  = !(exit_pkt.valid && out_valid_reg && !out_ready);
    assign op_in    = opcode_t'(opcode);
    assign slot_range = (op_in != OP_TICK) && (opcode <= OP_QUERY)
                        && (32'(slot) >= TASK_SLOTS);

    // Load a new request into the chain entry
    always_comb
    begin
        entry_next = entry_reg;
        if (accept)
        begin
            entry_next.valid        = 1'b1;
            entry_next.op           = op_in;
            entry_next.slot         = slot;
            entry_next.period       = period;
            entry_next.first_delay  = first_delay;
            entry_next.suspend_time = suspend_time;
            entry_next.status       = slot_range ? ST_RANGE : ST_OK;
            entry_next.task_state   = MODE_EMPTY;
            entry_next.fire_mask    = '0;
        end
        else if (advance)
        begin
            entry_next.valid = 1'b0;
        end
    end

    // Capture the result at the chain end and track the busy flag
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        state_next     = state_reg;
        mask_next      = mask_reg;
        if (accept)
            busy_next = 1'b1;
        if (exit_pkt.valid && advance)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            status_next    = exit_pkt.status;
            state_next     = exit_pkt.task_state;
            mask_next      = exit_pkt.fire_mask;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            entry_reg     <= entry_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        state_reg  <= state_next;
        mask_reg   <= mask_next;
    end

    assign chain[0] = entry_reg;

    // Build the slot chain
    for (genvar i = 0; i < TASK_SLOTS; i++)
    begin : g_cell
        ptts_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .pkt_in  (chain[i]),
            .pkt_out (chain[i+1])
        );
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign task_state = state_reg;
    assign fire_mask  = mask_reg;

endmodule

// ===== sv/ptts_chk.sv =====
module ptts_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [1:0] task_state,
    input logic [7:0] fire_mask
);
    import ptts_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(task_state) && $stable(fire_mask))
        else $error("stalled result changed");

    // Take one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // Never answer a request in the cycle after it arrives
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

    // Drop state and mask on a failed request
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (task_state == MODE_EMPTY) && (fire_mask == '0))
        else $error("failed request carries state or mask");

    // Report a queried state only on non-tick results
    a_query_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (task_state != MODE_EMPTY) |-> (fire_mask == '0))
        else $error("query result carries fire mask");

endmodule

bind periodic_task_tick_scheduler ptts_chk u_ptts_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .task_state (task_state),
    .fire_mask  (fire_mask)
);

// ===== tb/ptts_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the scheduler, keeps its own copy of the slot
// table and checks every result against the request that caused it.
module ptts_checker #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [ptts_pkg::OP_W-1:0]     opcode,
    input  logic [ptts_pkg::SLOT_W-1:0]   slot,
    input  logic [ptts_pkg::CNT_W-1:0]    period,
    input  logic [ptts_pkg::CNT_W-1:0]    first_delay,
    input  logic [ptts_pkg::SUS_W-1:0]    suspend_time,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [1:0]                    status,
    input  logic [1:0]                    task_state,
    input  logic [ptts_pkg::MASK_W-1:0]   fire_mask,
    output int                            mismatches,
    output int                            pending
);
    import ptts_pkg::*;

    typedef struct packed {
        status_t           status;
        mode_t             task_state;
        logic [MASK_W-1:0] fire_mask;
    } sched_result_t;

    // Shadow slot table
    mode_t             shadow_mode     [TASK_SLOTS];
    logic [CNT_W-1:0]  shadow_countdown[TASK_SLOTS];
    logic [CNT_W-1:0]  shadow_reload   [TASK_SLOTS];
    logic [SUS_W-1:0]  shadow_suspend  [TASK_SLOTS];

    sched_result_t     awaited_results[$];
    int                error_count;

    // Advance every slot by one tick and return the slots that fired
    function automatic logic [MASK_W-1:0] advance_tick();
        logic [MASK_W-1:0] fired;
        fired = '0;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            case (shadow_mode[i])
                MODE_READY:
                    if (shadow_countdown[i] == '0)
                    begin
                        if (i < MASK_W)
                            fired[i] = 1'b1;
                        shadow_mode[i]      = MODE_RUNNING;
                        shadow_countdown[i] = shadow_reload[i];
                    end
                    else
                        shadow_countdown[i] = shadow_countdown[i] - 1'b1;
                MODE_RUNNING:
                    if (shadow_countdown[i] == '0)
                        shadow_mode[i] = MODE_READY;
                    else
                        shadow_countdown[i] = shadow_countdown[i] - 1'b1;
                MODE_SUSPENDED:
                    if (shadow_suspend[i] == '0)
                        shadow_mode[i] = MODE_READY;
                    else
                        shadow_suspend[i] = shadow_suspend[i] - 1'b1;
                default: ;
            endcase
        end
        return fired;
    endfunction

    // Apply one request to the shadow table and return its result
    function automatic sched_result_t apply_request(
        input logic [OP_W-1:0]   op,
        input logic [SLOT_W-1:0] idx,
        input logic [CNT_W-1:0]  new_period,
        input logic [CNT_W-1:0]  new_delay,
        input logic [SUS_W-1:0]  new_suspend
    );
        sched_result_t r;
        int            k;
        logic          is_empty;
        r.status     = ST_OK;
        r.task_state = MODE_EMPTY;
        r.fire_mask  = '0;
        if (op == OP_TICK)
            r.fire_mask = advance_tick();
        else if (op <= OP_QUERY)
        begin
            if (int'(idx) >= TASK_SLOTS)
                r.status = ST_RANGE;
            else
            begin
                k        = int'(idx);
                is_empty = (shadow_mode[k] == MODE_EMPTY);
                case (op)
                    OP_CREATE:
                        if (!is_empty)
                            r.status = ST_TAKEN;
                        else
                        begin
                            shadow_reload[k]    = new_period;
                            shadow_countdown[k] = new_delay;
                            shadow_suspend[k]   = '0;
                            shadow_mode[k]      = MODE_READY;
                        end
                    OP_DELETE:
                    begin
                        shadow_mode[k]      = MODE_EMPTY;
                        shadow_countdown[k] = '0;
                        shadow_reload[k]    = '0;
                        shadow_suspend[k]   = '0;
                    end
                    OP_SUSPEND:
                        if (is_empty)
                            r.status = ST_EMPTY;
                        else
                        begin
                            shadow_mode[k]    = MODE_SUSPENDED;
                            shadow_suspend[k] = new_suspend;
                        end
                    OP_RESUME:
                        if (is_empty)
                            r.status = ST_EMPTY;
                        else
                            shadow_mode[k] = MODE_READY;
                    OP_QUERY:
                        if (is_empty)
                            r.status = ST_EMPTY;
                        else
                            r.task_state = shadow_mode[k];
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    // Retire results first, then record the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                shadow_mode[i]      = MODE_EMPTY;
                shadow_countdown[i] = '0;
                shadow_reload[i]    = '0;
                shadow_suspend[i]   = '0;
            end
            awaited_results.delete();
            error_count = 0;
            mismatches  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with no request waiting: status %0d state %0d mask %h",
                             $time, status, task_state, fire_mask);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                    if (task_state !== want.task_state)
                    begin
                        error_count++;
                        $display("%0t: task_state expected %0d actual %0d",
                                 $time, want.task_state, task_state);
                    end
                    if (fire_mask !== want.fire_mask)
                    begin
                        error_count++;
                        $display("%0t: fire_mask expected %h actual %h",
                                 $time, want.fire_mask, fire_mask);
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_request(opcode, slot, period,
                                                        first_delay, suspend_time));
            mismatches <= error_count;
            pending    <= awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_periodic_task_tick_scheduler.sv =====
`timescale 1ns / 100ps

module tb_periodic_task_tick_scheduler;
    import ptts_pkg::*;

    localparam int TASK_SLOTS    = 8;
    localparam int RANDOM_ITEMS  = 950;
    localparam int IDLE_LIMIT    = 4000;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     opcode;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    period;
    logic [CNT_W-1:0]    first_delay;
    logic [SUS_W-1:0]    suspend_time;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          status;
    logic [1:0]          task_state;
    logic [MASK_W-1:0]   fire_mask;

    int                  mismatches;
    int                  pending;
    int                  idle_cycles;
    int                  rx_hold;
    bit                  rx_free;
    bit                  tx_free;

    periodic_task_tick_scheduler #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .slot(slot),
        .period(period),
        .first_delay(first_delay),
        .suspend_time(suspend_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .task_state(task_state),
        .fire_mask(fire_mask)
    );

    ptts_checker #(
        .TASK_SLOTS(TASK_SLOTS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .slot(slot),
        .period(period),
        .first_delay(first_delay),
        .suspend_time(suspend_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .task_state(task_state),
        .fire_mask(fire_mask),
        .mismatches(mismatches),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the result side: free-running stretches and random holds
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            rx_free <= !rx_free;
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_free && $urandom_range(0, 3) == 0)
                rx_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                        : $urandom_range(1, 3);
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("periodic_task_tick_scheduler: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Hold a request on the input channel until it is taken
    task automatic issue_request(
        input logic [OP_W-1:0]   op,
        input logic [SLOT_W-1:0] idx,
        input logic [CNT_W-1:0]  new_period,
        input logic [CNT_W-1:0]  new_delay,
        input logic [SUS_W-1:0]  new_suspend
    );
        in_valid     <= 1'b1;
        opcode       <= op;
        slot         <= idx;
        period       <= new_period;
        first_delay  <= new_delay;
        suspend_time <= new_suspend;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Idle the input side for a random stretch
    task automatic sender_gap();
        int n;
        n = 0;
        if (!tx_free)
        begin
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(20, 60);
                1, 2, 3,
                4, 5:    n = $urandom_range(3, 8);
                default: n = $urandom_range(0, 2);
            endcase
        end
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly short counts so slots fire often, now and then the full range
    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            0:          return CNT_W'($urandom_range(0, 65535));
            1, 2, 3:    return CNT_W'($urandom_range(0, 40));
            default:    return CNT_W'($urandom_range(0, 6));
        endcase
    endfunction

    task automatic random_request();
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] idx;
        logic [SUS_W-1:0]  hold;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = OP_TICK;
        else if (pick < 55)
            op = OP_CREATE;
        else if (pick < 63)
            op = OP_DELETE;
        else if (pick < 75)
            op = OP_SUSPEND;
        else if (pick < 83)
            op = OP_RESUME;
        else if (pick < 95)
            op = OP_QUERY;
        else if (pick < 97)
            op = OP_SPARE_LO;
        else
            op = OP_SPARE_HI;
        idx  = ($urandom_range(0, 6) == 0) ? SLOT_W'($urandom_range(TASK_SLOTS, 15))
                                           : SLOT_W'($urandom_range(0, TASK_SLOTS - 1));
        hold = ($urandom_range(0, 4) == 0) ? SUS_W'($urandom_range(0, 255))
                                           : SUS_W'($urandom_range(0, 5));
        issue_request(op, idx, pick_count(), pick_count(), hold);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_TICK;
        slot         <= '0;
        period       <= '0;
        first_delay  <= '0;
        suspend_time <= '0;
        out_ready    <= 1'b0;
        rx_hold      <= 0;
        rx_free      <= 1'b0;
        idle_cycles  <= 0;
        tx_free       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty slots and out-of-range slots
        issue_request(OP_QUERY,   4'd0,  '0, '0, '0);
        issue_request(OP_SUSPEND, 4'd1,  '0, '0, 8'd4);
        issue_request(OP_RESUME,  4'd2,  '0, '0, '0);
        issue_request(OP_DELETE,  4'd3,  '0, '0, '0);
        issue_request(OP_CREATE,  4'd8,  16'd3, 16'd3, '0);
        issue_request(OP_QUERY,   4'd15, '0, '0, '0);
        issue_request(OP_SUSPEND, 4'd9,  '0, '0, 8'd1);
        issue_request(OP_RESUME,  4'd12, '0, '0, '0);
        issue_request(OP_DELETE,  4'd10, '0, '0, '0);
        // Fire at once, taken slot, largest counts
        issue_request(OP_CREATE,  4'd0,  16'd0, 16'd0, '0);
        issue_request(OP_CREATE,  4'd0,  16'd5, 16'd5, '0);
        issue_request(OP_CREATE,  4'd7,  16'hFFFF, 16'hFFFF, '0);
        issue_request(OP_CREATE,  4'd1,  16'd1, 16'd2, '0);
        issue_request(OP_TICK,    4'd0,  '0, '0, '0);
        issue_request(OP_TICK,    4'd5,  '0, '0, '0);
        issue_request(OP_QUERY,   4'd0,  '0, '0, '0);
        // Zero-length suspend returns to ready on the next tick; long suspend, resume, spare opcodes
        issue_request(OP_SUSPEND, 4'd1,  '0, '0, 8'd0);
        issue_request(OP_TICK,    4'd0,  '0, '0, '0);
        issue_request(OP_SUSPEND, 4'd7,  '0, '0, 8'hFF);
        issue_request(OP_QUERY,   4'd7,  '0, '0, '0);
        issue_request(OP_RESUME,  4'd7,  '0, '0, '0);
        issue_request(OP_SPARE_LO, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
        issue_request(OP_SPARE_HI, 4'd0,  '0, '0, '0);
        issue_request(OP_DELETE,  4'd0,  '0, '0, '0);
        issue_request(OP_TICK,    4'd0,  '0, '0, '0);
        drain_results();

        // Random traffic with bursts of back-to-back requests
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) == 0)
                tx_free = !tx_free;
            random_request();
            sender_gap();
            if ($urandom_range(0, 199) == 0)
                drain_results();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4 * (TASK_SLOTS + 2)) @(posedge clk);
        if (mismatches == 0)
            $display("periodic_task_tick_scheduler: match");
        else
            $display("periodic_task_tick_scheduler: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ptts_pkg.sv
sv/ptts_cell.sv
sv/periodic_task_tick_scheduler.sv
sv/ptts_chk.sv
tb/ptts_checker.sv
tb/tb_periodic_task_tick_scheduler.sv
